// File: rtl/core/ptscd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ptscd_pkg
// Shared widths, codes and types of the point to sampled curve distance block.
// -----------------------------------------------------------------------------
package ptscd_pkg;

  localparam int unsigned MAX_SIDE_DEF = 64;

  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned STORE_DEPTH = 1 << ADDR_W;
  localparam int unsigned COORD_W     = 24;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned DIST_W      = 25;
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned ERR_W       = 27;
  localparam int unsigned OPW         = 27;
  localparam int unsigned PROD_W      = 2 * OPW;
  localparam int unsigned DOT_W       = 52;
  localparam int unsigned LEN_W       = 51;
  localparam int unsigned T_FRAC      = 16;
  localparam int unsigned T_W         = T_FRAC + 1;
  localparam int unsigned SUM_W       = 54;
  localparam int unsigned ROOT_W      = SUM_W / 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 7;

  localparam logic [T_W-1:0]       T_ONE            = T_W'(1) << T_FRAC;
  localparam logic [DIST_W-1:0]    DIST_MAX         = '1;
  localparam logic [CNT_W-1:0]     SAMPLE_COUNT_RST = CNT_W'(64);
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b1;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_W,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_CMP,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    PH_DOT,
    PH_SCALE,
    PH_SQ
  } phase_e;

  typedef struct packed {
    logic                      is_query;
    logic [ADDR_W-1:0]         index;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic             patch_mode;
    logic [CNT_W-1:0] sample_count;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] min_dist;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/ptscd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ptscd_in_if
// Input item channel: load a sample point or ask a distance query.
// -----------------------------------------------------------------------------
interface ptscd_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [ptscd_pkg::ADDR_W-1:0]       point_index;
  logic signed [ptscd_pkg::COORD_W-1:0] coord_x;
  logic signed [ptscd_pkg::COORD_W-1:0] coord_y;
  logic signed [ptscd_pkg::COORD_W-1:0] coord_z;

  modport source (output valid, action, point_index, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, action, point_index, coord_x, coord_y, coord_z,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/ptscd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ptscd_out_if
// Result item channel: least distance of one query.
// -----------------------------------------------------------------------------
interface ptscd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ptscd_pkg::DIST_W-1:0] min_distance;

  modport source (output valid, min_distance, input ready);
  modport sink (input valid, min_distance, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ptscd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ptscd_front
// Accept input items, classify load or query, and queue them for the back end.
// -----------------------------------------------------------------------------
module ptscd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  ptscd_in_if.sink            in_i,
  output ptscd_pkg::cmd_req_t req_o,
  input  logic                req_ready_i
);
  import ptscd_pkg::*;

  cmd_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_in;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = req_o.valid && req_ready_i;

  always_comb begin
    cmd_in.is_query = (in_i.action == ACT_QUERY);
    cmd_in.index    = in_i.point_index;
    cmd_in.x        = in_i.coord_x;
    cmd_in.y        = in_i.coord_y;
    cmd_in.z        = in_i.coord_z;
  end

  always_comb begin
    req_o.valid = (cnt_q != 2'd0);
    req_o.cmd   = buf_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= cmd_in;
  end

endmodule
`default_nettype wire

// File: rtl/core/ptscd_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ptscd_isqrt
// Floor square root, two radicand bits per cycle.
// -----------------------------------------------------------------------------
module ptscd_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ptscd_pkg::SUM_W-1:0]    value_i,
  output logic                           done_o,
  output logic [ptscd_pkg::ROOT_W-1:0]   root_o
);
  import ptscd_pkg::*;

  localparam logic [SUM_W-1:0] BIT_START = SUM_W'(1) << (SUM_W - 2);

  logic             busy_q, done_q;
  logic [SUM_W-1:0] v_q, res_q, bit_q;
  logic [SUM_W-1:0] trial;

  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == SUM_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= BIT_START;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ptscd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ptscd_back
// Sample store and cell engine: walk every segment or grid cell, project,
// accumulate the least squared distance and take its square root.
// -----------------------------------------------------------------------------
module ptscd_back #(
  parameter int unsigned MAX_SIDE = ptscd_pkg::MAX_SIDE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptscd_pkg::cmd_req_t req_i,
  output logic                req_ready_o,
  input  ptscd_pkg::cfg_t     cfg_i,
  output ptscd_pkg::res_t     res_o,
  input  logic                res_ready_i
);
  import ptscd_pkg::*;

  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);

  back_state_e state_q, state_d;
  phase_e      phase_q;
  logic [3:0]  step_q;
  logic [3:0]  dcnt_q;
  logic        edge_q;
  logic [ADDR_W-1:0] loc_q;
  logic [SIDE_W-1:0] i_q, j_q;

  logic [3*COORD_W-1:0] mem_q [STORE_DEPTH];
  logic [3*COORD_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 mem_we;

  logic signed [COORD_W-1:0] p_q [3];
  logic signed [COORD_W-1:0] a_q [3];
  logic signed [COORD_W-1:0] b_q [3];
  logic signed [COORD_W-1:0] c_q [3];
  logic signed [DIFF_W-1:0]  pa_q [3];
  logic signed [DIFF_W-1:0]  d1_q [3];
  logic signed [DIFF_W-1:0]  d2_q [3];
  logic signed [ERR_W-1:0]   e_q [3];
  logic signed [DOT_W-1:0]   dot1_q, dot2_q, cur_dot;
  logic [LEN_W-1:0]          len1_q, len2_q, cur_len;
  logic [T_W-1:0]            u_q, v_q;
  logic [DOT_W-1:0]          num_q, num_sh;
  logic [T_FRAC-1:0]         quo_q, quo_nx;
  logic                      num_ge;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [OPW-1:0]     op_a, op_b;
  logic [SUM_W-1:0]          sum_q, best_q;
  logic [DIST_W-1:0]         dist_q;

  logic [SIDE_W-1:0] side, side_m2;
  logic              last_step, div_zero, div_one, cell_last, edge_more;
  logic [1:0]        k_sel, m_sel;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] root;
  logic              rnd_neg;
  logic [PROD_W-1:0] rnd_mag, rnd_abs;
  logic [ERR_W-1:0]  rnd;

  always_comb begin
    if (cfg_i.sample_count < CNT_W'(2)) begin
      side = SIDE_W'(2);
    end else if (32'(cfg_i.sample_count) > MAX_SIDE) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(cfg_i.sample_count);
    end
    side_m2 = side - SIDE_W'(2);
  end

  always_comb begin
    unique case (phase_q)
      PH_DOT: begin
        k_sel     = step_q[3:2];
        m_sel     = step_q[1:0];
        last_step = (step_q == (cfg_i.patch_mode ? 4'd11 : 4'd7));
      end
      PH_SCALE: begin
        k_sel     = step_q[2:1];
        m_sel     = {1'b0, step_q[0]};
        last_step = (step_q == (cfg_i.patch_mode ? 4'd5 : 4'd3));
      end
      default: begin
        k_sel     = step_q[1:0];
        m_sel     = 2'd0;
        last_step = (step_q == (cfg_i.patch_mode ? 4'd2 : 4'd1));
      end
    endcase
  end

  always_comb begin
    cur_dot  = edge_q ? dot2_q : dot1_q;
    cur_len  = edge_q ? len2_q : len1_q;
    div_zero = (cur_len == '0) || cur_dot[DOT_W-1] || (cur_dot == '0);
    div_one  = !div_zero && ($unsigned(cur_dot) >= DOT_W'(cur_len));
    num_sh   = {num_q[DOT_W-2:0], 1'b0};
    num_ge   = (num_sh >= DOT_W'(cur_len));
    quo_nx   = {quo_q[T_FRAC-2:0], num_ge};
    edge_more = !edge_q && cfg_i.patch_mode;
    cell_last = cfg_i.patch_mode ? (i_q == side_m2 && j_q == side_m2)
                                 : (j_q == side_m2);
  end

  always_comb begin
    unique case (phase_q)
      PH_DOT: begin
        op_a = (m_sel == 2'd1) ? OPW'(d1_q[k_sel]) :
               (m_sel == 2'd3) ? OPW'(d2_q[k_sel]) : OPW'(pa_q[k_sel]);
        op_b = m_sel[1] ? OPW'(d2_q[k_sel]) : OPW'(d1_q[k_sel]);
      end
      PH_SCALE: begin
        op_a = m_sel[0] ? $signed(OPW'(v_q)) : $signed(OPW'(u_q));
        op_b = m_sel[0] ? OPW'(d2_q[k_sel]) : OPW'(d1_q[k_sel]);
      end
      default: begin
        op_a = OPW'(e_q[k_sel]);
        op_b = OPW'(e_q[k_sel]);
      end
    endcase
  end

  always_comb begin
    rnd_neg = prod_q[PROD_W-1];
    rnd_abs = rnd_neg ? $unsigned(-prod_q) : $unsigned(prod_q);
    rnd_mag = (rnd_abs + (PROD_W'(1) << (T_FRAC - 1))) >> T_FRAC;
    rnd     = rnd_neg ? ERR_W'(-rnd_mag) : ERR_W'(rnd_mag);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid && req_i.cmd.is_query) state_d = ST_RD_A;
      end
      ST_RD_A: state_d = ST_RD_B;
      ST_RD_B: state_d = ST_RD_C;
      ST_RD_C: state_d = ST_RD_W;
      ST_RD_W: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC: begin
        if (!last_step) begin
          state_d = ST_MUL;
        end else begin
          unique case (phase_q)
            PH_DOT:   state_d = ST_DIV_INIT;
            PH_SCALE: state_d = ST_MUL;
            default:  state_d = ST_CMP;
          endcase
        end
      end
      ST_DIV_INIT: begin
        if (div_zero || div_one) state_d = edge_more ? ST_DIV_INIT : ST_MUL;
        else state_d = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (dcnt_q == 4'd15) state_d = edge_more ? ST_DIV_INIT : ST_MUL;
      end
      ST_CMP:       state_d = cell_last ? ST_SQRT_GO : ST_RD_A;
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_done) state_d = ST_OUT;
      ST_OUT:       if (res_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o    = (state_q == ST_IDLE);
    mem_we         = (state_q == ST_IDLE) && req_i.valid && !req_i.cmd.is_query;
    sqrt_start     = (state_q == ST_SQRT_GO);
    res_o.valid    = (state_q == ST_OUT);
    res_o.min_dist = dist_q;
    unique case (state_q)
      ST_RD_B: rd_addr = loc_q + ADDR_W'(1);
      ST_RD_C: rd_addr = cfg_i.patch_mode ? loc_q + ADDR_W'(side) : loc_q;
      default: rd_addr = loc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_DOT;
      step_q  <= '0;
      dcnt_q  <= '0;
      edge_q  <= 1'b0;
      loc_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          loc_q <= '0;
          i_q   <= '0;
          j_q   <= '0;
        end
        ST_DIFF: begin
          phase_q <= PH_DOT;
          step_q  <= '0;
        end
        ST_ACC: begin
          if (!last_step) begin
            step_q <= step_q + 4'd1;
          end else begin
            step_q <= '0;
            unique case (phase_q)
              PH_DOT: begin
                phase_q <= PH_SCALE;
                edge_q  <= 1'b0;
              end
              PH_SCALE: phase_q <= PH_SQ;
              default:  phase_q <= PH_SQ;
            endcase
          end
        end
        ST_DIV_INIT: begin
          dcnt_q <= '0;
          if ((div_zero || div_one) && edge_more) edge_q <= 1'b1;
        end
        ST_DIV_RUN: begin
          dcnt_q <= dcnt_q + 4'd1;
          if (dcnt_q == 4'd15 && edge_more) edge_q <= 1'b1;
        end
        ST_CMP: begin
          if (!cell_last) begin
            if (cfg_i.patch_mode && j_q == side_m2) begin
              j_q   <= '0;
              i_q   <= i_q + SIDE_W'(1);
              loc_q <= loc_q + ADDR_W'(2);
            end else begin
              j_q   <= j_q + SIDE_W'(1);
              loc_q <= loc_q + ADDR_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[req_i.cmd.index] <= {req_i.cmd.x, req_i.cmd.y, req_i.cmd.z};
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    unique case (state_q)
      ST_IDLE: begin
        p_q[0] <= req_i.cmd.x;
        p_q[1] <= req_i.cmd.y;
        p_q[2] <= req_i.cmd.z;
        best_q <= '1;
      end
      ST_RD_B: begin
        a_q[0] <= rd_data_q[3*COORD_W-1 -: COORD_W];
        a_q[1] <= rd_data_q[2*COORD_W-1 -: COORD_W];
        a_q[2] <= rd_data_q[COORD_W-1:0];
      end
      ST_RD_C: begin
        b_q[0] <= rd_data_q[3*COORD_W-1 -: COORD_W];
        b_q[1] <= rd_data_q[2*COORD_W-1 -: COORD_W];
        b_q[2] <= rd_data_q[COORD_W-1:0];
      end
      ST_RD_W: begin
        c_q[0] <= rd_data_q[3*COORD_W-1 -: COORD_W];
        c_q[1] <= rd_data_q[2*COORD_W-1 -: COORD_W];
        c_q[2] <= rd_data_q[COORD_W-1:0];
      end
      ST_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          pa_q[k] <= DIFF_W'(p_q[k]) - DIFF_W'(a_q[k]);
          d1_q[k] <= DIFF_W'(b_q[k]) - DIFF_W'(a_q[k]);
          d2_q[k] <= DIFF_W'(c_q[k]) - DIFF_W'(a_q[k]);
          e_q[k]  <= ERR_W'(DIFF_W'(p_q[k]) - DIFF_W'(a_q[k]));
        end
        dot1_q <= '0;
        dot2_q <= '0;
        len1_q <= '0;
        len2_q <= '0;
        sum_q  <= '0;
        v_q    <= '0;
      end
      ST_ACC: begin
        unique case (phase_q)
          PH_DOT: begin
            unique case (m_sel)
              2'd0: dot1_q <= dot1_q + DOT_W'(prod_q);
              2'd1: len1_q <= len1_q + LEN_W'(prod_q);
              2'd2: dot2_q <= dot2_q + DOT_W'(prod_q);
              default: len2_q <= len2_q + LEN_W'(prod_q);
            endcase
          end
          PH_SCALE: e_q[k_sel] <= e_q[k_sel] - $signed(rnd);
          default:  sum_q <= sum_q + $unsigned(prod_q);
        endcase
      end
      ST_DIV_INIT: begin
        num_q <= $unsigned(cur_dot);
        quo_q <= '0;
        if (div_zero || div_one) begin
          if (edge_q) v_q <= div_one ? T_ONE : '0;
          else u_q <= div_one ? T_ONE : '0;
        end
      end
      ST_DIV_RUN: begin
        num_q <= num_ge ? num_sh - DOT_W'(cur_len) : num_sh;
        quo_q <= quo_nx;
        if (dcnt_q == 4'd15) begin
          if (edge_q) v_q <= {1'b0, quo_nx};
          else u_q <= {1'b0, quo_nx};
        end
      end
      ST_CMP: begin
        if (sum_q < best_q) best_q <= sum_q;
      end
      ST_SQRT_WAIT: begin
        dist_q <= (root > ROOT_W'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
      end
      default: ;
    endcase
  end

  ptscd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (best_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  a_param_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && phase_q == PH_SCALE) |-> (u_q <= T_ONE && v_q <= T_ONE))
    else $error("projection parameter above one");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_RUN) |-> (num_q < DOT_W'(cur_len)))
    else $error("divider remainder not below divisor");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (step_q <= 4'd11))
    else $error("step counter overran");

  a_sqrt_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT_WAIT && sqrt_done) |=> res_o.valid)
    else $error("root finished without a result");

endmodule
`default_nettype wire

// File: rtl/core/point_to_sampled_curve_distance.sv
// Load item: queued, then stored when the back end is idle; no result.
// Query item: each segment (curve) or grid cell (patch) runs through the shared
// multiplier steps and the bit-serial divider, then the square root and output;
// one query at a time. Reset clears the control state, the settings
// (patch_mode 0, sample_count 64) and the queues; the sample store holds no
// defined value until written.
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// point_to_sampled_curve_distance
// Least distance from a query point to a sampled polyline or grid patch.
// -----------------------------------------------------------------------------
module point_to_sampled_curve_distance #(
  parameter int unsigned MAX_SIDE = ptscd_pkg::MAX_SIDE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ptscd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ptscd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  ptscd_in_if.sink                            in_i,
  ptscd_out_if.source                         out_o
);
  import ptscd_pkg::*;

  cfg_t              cfg_q;
  cmd_req_t          req;
  logic              req_ready;
  res_t              res;
  logic              res_ready;
  logic              out_valid_q;
  logic [DIST_W-1:0] out_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.patch_mode   <= 1'b0;
      cfg_q.sample_count <= SAMPLE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATCH_MODE:   cfg_q.patch_mode   <= cfg_data_i[0];
        CFG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) out_dist_q <= res.min_dist;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.min_distance = out_dist_q;

  ptscd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  ptscd_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_ready_o (req_ready),
    .cfg_i       (cfg_q),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

endmodule
`default_nettype wire

// File: sim/point_to_sampled_curve_distance_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// point_to_sampled_curve_distance_tb
// Loads the sample store, then sends distance queries in curve and patch mode
// under several sample counts with random idling on both channels, and checks
// every returned distance against a local fixed-point distance model.
// -----------------------------------------------------------------------------
module point_to_sampled_curve_distance_tb;
  import ptscd_pkg::*;

  localparam int unsigned SIDE_MAX      = 64;
  localparam int unsigned SILENCE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct {
    action_e                   act;
    logic [ADDR_W-1:0]         idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_item_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ptscd_in_if  in_ch ();
  ptscd_out_if out_ch ();

  point_to_sampled_curve_distance DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  point_item_t       pending_points[$];
  logic [DIST_W-1:0] dist_expected[$];
  longint            store_x[STORE_DEPTH];
  longint            store_y[STORE_DEPTH];
  longint            store_z[STORE_DEPTH];
  logic              mdl_patch;
  int unsigned       mdl_count;
  int unsigned       send_gap;
  int unsigned       recv_stall;
  int unsigned       silent_cycles;
  int unsigned       error_count;
  bit                quiet;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [DIST_W-1:0] got,
                        input logic [DIST_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic longint unsigned edge_param(longint dot, longint unsigned len);
    longint unsigned num;
    longint unsigned q;
    if (len == 0 || dot <= 0) return 0;
    num = dot;
    if (num >= len) return 64'd1 << T_FRAC;
    q = 0;
    for (int k = 0; k < T_FRAC; k++) begin
      num = num << 1;
      q = q << 1;
      if (num >= len) begin
        num -= len;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint scale_term(longint unsigned t, longint d);
    longint          prod;
    longint unsigned m;
    prod = longint'(t) * d;
    m = (prod < 0) ? -prod : prod;
    m = (m + (64'd1 << (T_FRAC - 1))) >> T_FRAC;
    return (prod < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned cell_sq_dist(longint p[3], int unsigned ia,
                                                   int unsigned ib, int unsigned ic,
                                                   int dims, bit two_edges);
    longint          a[3], b[3], c[3], pa[3], d1[3], d2[3];
    longint          dot1, dot2, e;
    longint unsigned len1, len2, u, v, sum;
    ia &= STORE_DEPTH - 1;
    ib &= STORE_DEPTH - 1;
    ic &= STORE_DEPTH - 1;
    a = '{store_x[ia], store_y[ia], store_z[ia]};
    b = '{store_x[ib], store_y[ib], store_z[ib]};
    c = '{store_x[ic], store_y[ic], store_z[ic]};
    dot1 = 0; dot2 = 0; len1 = 0; len2 = 0; sum = 0; v = 0;
    for (int k = 0; k < dims; k++) begin
      pa[k] = p[k] - a[k];
      d1[k] = b[k] - a[k];
      d2[k] = c[k] - a[k];
      dot1 += pa[k] * d1[k];
      len1 += d1[k] * d1[k];
      dot2 += pa[k] * d2[k];
      len2 += d2[k] * d2[k];
    end
    u = edge_param(dot1, len1);
    if (two_edges) v = edge_param(dot2, len2);
    for (int k = 0; k < dims; k++) begin
      e = pa[k] - scale_term(u, d1[k]);
      if (two_edges) e -= scale_term(v, d2[k]);
      sum += e * e;
    end
    return sum;
  endfunction

  function automatic logic [DIST_W-1:0] nearest_distance(point_item_t it);
    longint          p[3];
    longint unsigned best, s, root;
    int unsigned     n, loc;
    p = '{longint'(it.x), longint'(it.y), longint'(it.z)};
    best = '1;
    n = mdl_count;
    if (n < 2) n = 2;
    if (n > SIDE_MAX) n = SIDE_MAX;
    if (!mdl_patch) begin
      for (int unsigned i = 0; i + 1 < n; i++) begin
        s = cell_sq_dist(p, i, i + 1, i, 2, 1'b0);
        if (s < best) best = s;
      end
    end else begin
      for (int unsigned i = 0; i + 1 < n; i++)
        for (int unsigned j = 0; j + 1 < n; j++) begin
          loc = n * i + j;
          s = cell_sq_dist(p, loc, loc + 1, loc + n, 3, 1'b1);
          if (s < best) best = s;
        end
    end
    root = floor_sqrt(best);
    if (root > DIST_MAX) root = DIST_MAX;
    return root[DIST_W-1:0];
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        point_item_t it;
        it = pending_points.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= it.act;
        in_ch.point_index <= it.idx;
        in_ch.coord_x <= it.x;
        in_ch.coord_y <= it.y;
        in_ch.coord_z <= it.z;
        send_gap <= quiet ? 0 : $urandom_range(0, 3);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_stall <= 0;
      silent_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        silent_cycles <= 0;
      end else begin
        silent_cycles <= silent_cycles + 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        point_item_t it;
        it = '{action_e'(in_ch.action), in_ch.point_index,
               in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};
        if (it.act == ACT_LOAD) begin
          store_x[it.idx] = it.x;
          store_y[it.idx] = it.y;
          store_z[it.idx] = it.z;
        end else begin
          dist_expected = {dist_expected, nearest_distance(it)};
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (dist_expected.size() == 0) begin
          report("unexpected distance", out_ch.min_distance, '0);
        end else begin
          logic [DIST_W-1:0] want;
          want = dist_expected.pop_front();
          if (out_ch.min_distance !== want) report("min_distance", out_ch.min_distance, want);
        end
        recv_stall <= quiet ? 0 : $urandom_range(0, 3);
        out_ch.ready <= (quiet || $urandom_range(0, 3) == 0);
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if (silent_cycles >= SILENCE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 6))
      0: return COORD_W'($urandom());
      1: return 24'sh7FFFFF;
      2: return -24'sh800000;
      default: return COORD_W'($urandom_range(0, 1 << 19) - (1 << 18));
    endcase
  endfunction

  task automatic add_point(action_e act, int unsigned idx, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
    point_item_t it;
    it = '{act, idx[ADDR_W-1:0], x, y, z};
    pending_points = {pending_points, it};
  endtask

  task automatic wait_idle();
    while (pending_points.size() != 0 || in_ch.valid || dist_expected.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(bit patch, int unsigned count);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_PATCH_MODE;
    cfg_data_i <= CFG_DATA_W'(patch);
    @(posedge clk_i);
    cfg_index_i <= CFG_SAMPLE_COUNT;
    cfg_data_i <= CFG_DATA_W'(count);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_patch = patch;
    mdl_count = count;
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic random_points(int unsigned num_items);
    int unsigned n, span;
    n = mdl_count < 2 ? 2 : (mdl_count > SIDE_MAX ? SIDE_MAX : mdl_count);
    span = mdl_patch ? n * n : n;
    repeat (num_items) begin
      if ($urandom_range(0, 9) < 4) begin
        add_point(ACT_QUERY, $urandom(), pick_coord(), pick_coord(), pick_coord());
      end else if ($urandom_range(0, 3) == 0) begin
        add_point(ACT_LOAD, $urandom(), pick_coord(), pick_coord(), pick_coord());
      end else begin
        add_point(ACT_LOAD, $urandom_range(0, span - 1), pick_coord(), pick_coord(),
                  pick_coord());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_PATCH_MODE;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD;
    in_ch.point_index = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    out_ch.ready = 1'b0;
    error_count = 0;
    quiet = 1'b0;
    mdl_patch = 1'b0;
    mdl_count = 64;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill every slot that a query walks, up to a 64 point curve or an 8 by 8 grid
    for (int unsigned s = 0; s < 64; s++)
      add_point(ACT_LOAD, s, pick_coord(), pick_coord(), pick_coord());

    // reset settings: curve of 64 points
    add_point(ACT_LOAD, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    add_point(ACT_LOAD, 1, -24'sh800000, -24'sh800000, -24'sh800000);
    add_point(ACT_LOAD, 2, 24'sd4096, -24'sd8192, 24'sd0);
    add_point(ACT_LOAD, 3, 24'sd4096, -24'sd8192, 24'sd0);
    add_point(ACT_LOAD, 4095, 24'sh7FFFFF, -24'sh800000, 24'sh123456);
    add_point(ACT_QUERY, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh0);
    add_point(ACT_QUERY, 4095, -24'sh800000, -24'sh800000, -24'sh800000);
    add_point(ACT_QUERY, 0, 24'sd4096, -24'sd8192, 24'sd0);
    add_point(ACT_QUERY, 17, 24'sd0, 24'sd0, 24'sd0);
    add_point(ACT_QUERY, 1, 24'sd5000, -24'sd9000, 24'sh7FFFFF);

    set_mode(1'b0, 2);
    add_point(ACT_QUERY, 0, 24'sd0, 24'sd0, 24'sd0);
    random_points(9);
    set_mode(1'b1, 2);
    add_point(ACT_LOAD, 1, 24'sd0, 24'sd0, 24'sd0);
    add_point(ACT_LOAD, 0, 24'sd0, 24'sd0, 24'sd0);
    add_point(ACT_QUERY, 0, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
    add_point(ACT_QUERY, 0, -24'sh800000, 24'sh7FFFFF, -24'sh800000);
    random_points(8);
    set_mode(1'b0, 0);
    random_points(8);
    set_mode(1'b0, 127);
    random_points(8);
    set_mode(1'b1, 5);
    random_points(12);
    set_mode(1'b1, 3);
    random_points(10);
    set_mode(1'b1, 8);
    add_point(ACT_QUERY, 0, 24'sd1000, -24'sd1000, 24'sd0);
    set_mode(1'b0, 10);
    random_points(10);

    wait_idle();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
